[sv/sync_header_channel_deframer_assert.svh]
// Assertion macros for the sync header channel deframer.
// Used by sync_header_channel_deframer.sv; relies on clk and rst_n in scope.
`ifndef SYNC_HEADER_CHANNEL_DEFRAMER_ASSERT_SVH
`define SYNC_HEADER_CHANNEL_DEFRAMER_ASSERT_SVH

// Checked only outside reset
`define SHCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define SHCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/shcd_pkg.sv]
// Shared types and constants for the sync header channel deframer.
// No dependencies.
package shcd_pkg;

  // Framing phase
  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_FRAMENUM = 2'd1,
    PH_DATA     = 2'd2
  } phase_t;

  // Sync pair
  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hFE;

  // Side tag codes
  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_LEFT  = 2'd1;
  localparam logic [1:0] TAG_RIGHT = 2'd2;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned TAG_W   = 2;

endpackage

[sv/sync_header_channel_deframer.sv]
// Sync header channel deframer: top level and all datapath.
// Depends on shcd_pkg and sync_header_channel_deframer_assert.svh.

// Takes one received byte per request and hunts for the sync pair 0xFF 0xFE
// (a repeated 0xFF still counts as the first sync byte). After sync it
// captures a little-endian 16-bit frame number, then CHANNELS little-endian
// 16-bit words; each completed word leaves as one result request carrying
// its index, the frame number, the side tag (code 3 reads as none) and a
// last flag on the final word, after which hunting restarts. A frame is
// 4 + 2*CHANNELS bytes. Throughput is one byte per cycle while in_stall is low:
// the byte passes an input register, one short decode step and the result register,
// so a result is offered once its closing byte has passed both registers. in_stall
// is raised only while the input register is full and the result register is both
// full and stalled; out_stall reaches in_stall through one gate.
`include "sync_header_channel_deframer_assert.svh"

module sync_header_channel_deframer #(
  parameter int unsigned CHANNELS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [shcd_pkg::TAG_W-1:0]           cfg_wdata,
  // byte input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [shcd_pkg::BYTE_W-1:0]          in_rx_byte,
  // channel words out
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [shcd_pkg::WORD_W-1:0]          out_channel_value,
  output logic [shcd_pkg::INDEX_W-1:0]         out_channel_index,
  output logic [shcd_pkg::WORD_W-1:0]          out_frame_count,
  output logic [shcd_pkg::TAG_W-1:0]           out_source_tag,
  output logic                                 out_last_of_frame
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  // Registers
  logic                              s1_valid_r, s1_valid_nxt;
  logic [shcd_pkg::BYTE_W-1:0]       s1_byte_r;
  logic [shcd_pkg::TAG_W-1:0]        side_tag_r;
  shcd_pkg::phase_t                  phase_r, phase_nxt;
  logic                              saw_first_r, saw_first_nxt;
  logic                              half_r, half_nxt;
  logic [IDX_W-1:0]                  word_idx_r, word_idx_nxt;
  logic [shcd_pkg::BYTE_W-1:0]       low_byte_r, low_byte_nxt;
  logic [shcd_pkg::WORD_W-1:0]       frame_num_r, frame_num_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [shcd_pkg::WORD_W-1:0]       out_value_r;
  logic [shcd_pkg::INDEX_W-1:0]      out_index_r;
  logic [shcd_pkg::WORD_W-1:0]       out_frame_r;
  logic [shcd_pkg::TAG_W-1:0]        out_tag_r;
  logic                              out_last_r;

  // Decode
  logic                              in_take;
  logic                              advance;
  logic                              emit;
  logic                              last_word;
  logic [shcd_pkg::TAG_W-1:0]        tag_eff;
  logic [IDX_W+shcd_pkg::INDEX_W-1:0] idx_ext;

  // Handshake: the input register moves on when the result slot is free
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign last_word = (word_idx_r == LAST_IDX);
  assign tag_eff   = (side_tag_r == shcd_pkg::TAG_LEFT || side_tag_r == shcd_pkg::TAG_RIGHT)
                     ? side_tag_r : shcd_pkg::TAG_NONE;
  assign idx_ext   = {{shcd_pkg::INDEX_W{1'b0}}, word_idx_r};

  // Framing state machine, one byte per step
  always_comb begin
    phase_nxt     = phase_r;
    saw_first_nxt = saw_first_r;
    half_nxt      = half_r;
    word_idx_nxt  = word_idx_r;
    low_byte_nxt  = low_byte_r;
    frame_num_nxt = frame_num_r;
    emit          = 1'b0;
    unique case (phase_r)
      shcd_pkg::PH_FRAMENUM: begin
        if (!half_r) begin
          low_byte_nxt = s1_byte_r;
          half_nxt     = 1'b1;
        end else begin
          frame_num_nxt = {s1_byte_r, low_byte_r};
          phase_nxt     = shcd_pkg::PH_DATA;
          half_nxt      = 1'b0;
          word_idx_nxt  = '0;
        end
      end
      shcd_pkg::PH_DATA: begin
        if (!half_r) begin
          low_byte_nxt = s1_byte_r;
          half_nxt     = 1'b1;
        end else begin
          emit     = 1'b1;
          half_nxt = 1'b0;
          if (last_word) begin
            phase_nxt     = shcd_pkg::PH_HUNT;
            saw_first_nxt = 1'b0;
            word_idx_nxt  = '0;
          end else begin
            word_idx_nxt = word_idx_r + 1'b1;
          end
        end
      end
      default: begin
        // hunting, and any unused phase code
        phase_nxt = shcd_pkg::PH_HUNT;
        if (saw_first_r && s1_byte_r == shcd_pkg::SYNC_SECOND) begin
          phase_nxt     = shcd_pkg::PH_FRAMENUM;
          saw_first_nxt = 1'b0;
          half_nxt      = 1'b0;
          word_idx_nxt  = '0;
        end else begin
          saw_first_nxt = (s1_byte_r == shcd_pkg::SYNC_FIRST);
        end
      end
    endcase
  end

  // Input register occupancy and result valid
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      side_tag_r  <= shcd_pkg::TAG_NONE;
      phase_r     <= shcd_pkg::PH_HUNT;
      saw_first_r <= 1'b0;
      half_r      <= 1'b0;
      word_idx_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        side_tag_r <= cfg_wdata;
      end
      if (advance) begin
        phase_r     <= phase_nxt;
        saw_first_r <= saw_first_nxt;
        half_r      <= half_nxt;
        word_idx_r  <= word_idx_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      low_byte_r  <= low_byte_nxt;
      frame_num_r <= frame_num_nxt;
    end
    if (advance && emit) begin
      out_value_r <= {s1_byte_r, low_byte_r};
      out_index_r <= idx_ext[shcd_pkg::INDEX_W-1:0];
      out_frame_r <= frame_num_r;
      out_tag_r   <= tag_eff;
      out_last_r  <= last_word;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_value = out_value_r;
  assign out_channel_index = out_index_r;
  assign out_frame_count   = out_frame_r;
  assign out_source_tag    = out_tag_r;
  assign out_last_of_frame = out_last_r;

  // Checks
  `SHCD_ASSERT(a_stall_cause, in_stall |-> (s1_valid_r && out_valid_r && out_stall), "in_stall without a blocked result")
  `SHCD_ASSERT(a_emit_valid, (advance && emit) |=> out_valid_r, "word completed but no result request")
  `SHCD_ASSERT(a_last_hunt, (advance && emit && last_word) |=> (phase_r == shcd_pkg::PH_HUNT), "no return to hunting after the last word")
  `SHCD_ASSERT(a_hunt_clean, (phase_r == shcd_pkg::PH_HUNT) |-> (word_idx_r == '0 && !half_r), "stale word position while hunting")
  `SHCD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_r && !s1_valid_r), "request pending after reset")

endmodule
